FILE: design/greedy_indegree_node_ordering_macros.svh
// ----------------------------------------------------------------------------
// Greedy in-degree node ordering assertion macros
// Short forms for the concurrent checks used in the ordering block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_INDEGREE_NODE_ORDERING_MACROS_SVH
`define GREEDY_INDEGREE_NODE_ORDERING_MACROS_SVH

// Same-cycle implication, sampled on the block clock.
`define GINO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the block clock.
`define GINO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/gino_pkg.sv
// ----------------------------------------------------------------------------
// Greedy in-degree node ordering package
// Types, constants and helper functions shared by the ordering block.
// ----------------------------------------------------------------------------
`default_nettype none

package gino_pkg;

	localparam int NODE_MAX = 32;
	localparam int NODE_W = 5;
	localparam int CNT_W = 6;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd1;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_RUN = 1'b1;

	localparam logic [DATA_W-1:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [DATA_W-1:0] WEIGHT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic              action;
		logic [NODE_W-1:0] node_index;
		logic [DATA_W-1:0] parent_mask;
	} request_t;

	typedef struct packed {
		logic [NODE_W-1:0] picked_node;
		logic              last;
	} result_t;

	typedef struct packed {
		logic              go;
		logic [DATA_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] remainder;
	} mod_rsp_t;

	function automatic logic [CNT_W-1:0] pop_count(input logic [DATA_W-1:0] v);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int k = 0; k < DATA_W; k++) begin
			c = c + CNT_W'(v[k]);
		end
		return c;
	endfunction

	function automatic logic [DATA_W-1:0] lfsr_next(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: design/gino_mod_unit.sv
// ----------------------------------------------------------------------------
// Greedy in-degree node ordering remainder unit
// Bit-serial restoring remainder of a 32-bit value by a small divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module gino_mod_unit
	import gino_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mod_req_t req,
	output mod_rsp_t      rsp
);

	logic              busy_q;
	logic [NODE_W-1:0] step_q;
	logic [DATA_W-1:0] dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  rem_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    next_rem;

	always_comb begin
		trial = {rem_q, dvd_q[DATA_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			next_rem = trial - {1'b0, dvs_q};
		end else begin
			next_rem = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				step_q <= '0;
				dvd_q <= req.dividend;
				dvs_q <= req.divisor;
				rem_q <= '0;
			end else if (busy_q) begin
				rem_q <= next_rem[CNT_W-1:0];
				dvd_q <= dvd_q << 1;
				step_q <= step_q + 1'b1;
				if (step_q == NODE_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

FILE: design/greedy_indegree_node_ordering.sv
// Load request: written at its accepting edge; busy stays low, so loads go back to back.
// Run request over n nodes, per pick: in-degree counts, weights through the shared
// multiplier, a remainder step, a selection scan and an emit step. The next request
// can be taken in the same cycle as the last result. Results cannot be held off;
// each is valid for one cycle.
// Reset clears all parent rows and the unvisited set, sets node_count to 32, seed to 1.
// ----------------------------------------------------------------------------
// Greedy in-degree node ordering
// Loads parent rows and emits each of the first node_count nodes (at most 32) once in a greedy in-degree order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_indegree_node_ordering_macros.svh"

module greedy_indegree_node_ordering
	import gino_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire request_t             request,
	output logic                      result_valid,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CNT  = 3'd1;
	localparam logic [2:0] ST_WGT  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SEL  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [DATA_W-1:0] rows_q [NODE_MAX];
	logic [CNT_W-1:0]  cnt_q [NODE_MAX];
	logic [DATA_W-1:0] wgt_q [NODE_MAX];
	logic [DATA_W-1:0] unv_q;
	logic [DATA_W-1:0] lfsr_q;
	logic [CNT_W-1:0]  node_count_q;
	logic [DATA_W-1:0] seed_q;
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  c_q;
	logic [DATA_W-1:0] w_q;
	logic [CNT_W-1:0]  cur_cnt_q;
	logic              have_q;
	logic [CNT_W-1:0]  best_cnt_q;
	logic [DATA_W-1:0] best_w_q;
	logic [CNT_W-1:0]  ties_q;
	logic [CNT_W-1:0]  target_q;
	logic [NODE_W-1:0] pick_q;
	logic              go_q;
	logic              res_valid_q;
	result_t           res_q;

	logic [NODE_W-1:0]   rd_idx;
	logic [DATA_W-1:0]   row_rd;
	logic [CNT_W-1:0]    cnt_rd;
	logic [DATA_W+4:0]   prod;
	logic [CNT_W-1:0]    n_use;
	logic [DATA_W-1:0]   pick_bit;
	logic                sel_hit;
	mod_req_t            mreq;
	mod_rsp_t            mrsp;

	assign busy = (state_q != ST_IDLE);
	assign n_use = (node_count_q > CNT_W'(NODE_MAX)) ? CNT_W'(NODE_MAX) : node_count_q;

	always_comb begin
		case (state_q)
			ST_WGT:  rd_idx = c_q[NODE_W-1:0];
			default: rd_idx = i_q[NODE_W-1:0];
		endcase
	end

	assign row_rd = rows_q[rd_idx];
	assign cnt_rd = cnt_q[rd_idx];
	assign prod = (DATA_W+5)'(w_q) * (DATA_W+5)'(cnt_rd - 1'b1);
	assign pick_bit = DATA_W'(1) << pick_q;
	assign sel_hit = unv_q[i_q[NODE_W-1:0]] && (cnt_rd == best_cnt_q)
		&& (wgt_q[i_q[NODE_W-1:0]] == best_w_q);

	assign mreq.go = go_q;
	assign mreq.dividend = lfsr_q;
	assign mreq.divisor = ties_q;

	gino_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(NODE_MAX);
			seed_q <= DATA_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_COUNT:  node_count_q <= cfg_data[CNT_W-1:0];
				CFG_RANDOM_SEED: seed_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NODE_MAX; k++) begin
				rows_q[k] <= '0;
			end
		end else if (start && !busy && (request.action == ACT_LOAD)) begin
			rows_q[request.node_index] <= request.parent_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CNT) begin
			cnt_q[i_q[NODE_W-1:0]] <= pop_count(row_rd & unv_q);
		end
		if (state_q == ST_CMP) begin
			wgt_q[i_q[NODE_W-1:0]] <= w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			unv_q <= '0;
			lfsr_q <= DATA_W'(1);
			n_q <= '0;
			i_q <= '0;
			c_q <= '0;
			w_q <= DATA_W'(1);
			cur_cnt_q <= '0;
			have_q <= 1'b0;
			best_cnt_q <= '0;
			best_w_q <= '0;
			ties_q <= '0;
			target_q <= '0;
			pick_q <= '0;
			go_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			go_q <= 1'b0;
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && (request.action == ACT_RUN)) begin
						lfsr_q <= (seed_q != '0) ? seed_q : DATA_W'(1);
						n_q <= n_use;
						i_q <= '0;
						unv_q <= ~({DATA_W{1'b1}} << n_use);
						if (n_use != '0) begin
							state_q <= ST_CNT;
						end
					end
				end
				ST_CNT: begin
					if (i_q == n_q - 1'b1) begin
						i_q <= '0;
						c_q <= '0;
						w_q <= DATA_W'(1);
						have_q <= 1'b0;
						ties_q <= '0;
						state_q <= ST_WGT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_WGT: begin
					if (row_rd[i_q[NODE_W-1:0]] && (cnt_rd != '0)) begin
						w_q <= (prod[DATA_W+4:DATA_W] != '0) ? WEIGHT_MAX : prod[DATA_W-1:0];
					end
					if (c_q == i_q) begin
						cur_cnt_q <= cnt_rd;
					end
					if (c_q == n_q - 1'b1) begin
						state_q <= ST_CMP;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_CMP: begin
					if (unv_q[i_q[NODE_W-1:0]]) begin
						if (!have_q || (cur_cnt_q < best_cnt_q)
							|| ((cur_cnt_q == best_cnt_q) && (w_q < best_w_q))) begin
							have_q <= 1'b1;
							best_cnt_q <= cur_cnt_q;
							best_w_q <= w_q;
							ties_q <= CNT_W'(1);
						end else if ((cur_cnt_q == best_cnt_q) && (w_q == best_w_q)) begin
							ties_q <= ties_q + 1'b1;
						end
					end
					if (i_q == n_q - 1'b1) begin
						go_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						i_q <= i_q + 1'b1;
						c_q <= '0;
						w_q <= DATA_W'(1);
						state_q <= ST_WGT;
					end
				end
				ST_DIV: begin
					if (mrsp.done) begin
						target_q <= mrsp.remainder;
						lfsr_q <= lfsr_next(lfsr_q);
						i_q <= '0;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (sel_hit && (target_q == '0)) begin
						pick_q <= i_q[NODE_W-1:0];
						state_q <= ST_EMIT;
					end else begin
						if (sel_hit) begin
							target_q <= target_q - 1'b1;
						end
						i_q <= i_q + 1'b1;
					end
				end
				ST_EMIT: begin
					unv_q <= unv_q & ~pick_bit;
					res_valid_q <= 1'b1;
					res_q.picked_node <= pick_q;
					res_q.last <= ((unv_q & ~pick_bit) == '0);
					i_q <= '0;
					state_q <= ((unv_q & ~pick_bit) == '0) ? ST_IDLE : ST_CNT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	`GINO_ASSERT_NOW(a_last_ends_run, result_valid && result.last, !busy, "run still busy after last")
	`GINO_ASSERT_NOW(a_more_keeps_run, result_valid && !result.last, busy, "run ended before last")
	`GINO_ASSERT_NOW(a_pick_unvisited, state_q == ST_EMIT, unv_q[pick_q], "picked a visited node")
	`GINO_ASSERT_NEXT(a_ties_nonzero, go_q, ties_q != '0, "remainder started with no ties")

endmodule

`default_nettype wire

FILE: verif/tb_greedy_indegree_node_ordering.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy in-degree node ordering testbench
// Drives parent-row loads, ordering runs and register writes, and checks every
// picked node against an in-bench model of the greedy order or a directed row's
// expected picks. The directed rows run first, then mostly small random graphs.
// ----------------------------------------------------------------------------

module tb_greedy_indegree_node_ordering;
	import gino_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		request_t         req;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [DATA_W-1:0] cfg_val;
		int               exp_n;
		result_t          exp0;
		result_t          exp1;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	request_t request;
	logic result_valid;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	logic [DATA_W-1:0] model_rows [NODE_MAX];
	logic [DATA_W-1:0] model_unvisited;
	logic [DATA_W-1:0] model_lfsr;
	logic [CNT_W-1:0] model_count;
	logic [DATA_W-1:0] model_seed;

	result_t pending_picks[$];
	int errors;
	int stall_cycles;
	bit allow_gaps;

	greedy_indegree_node_ordering DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result_valid(result_valid), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void order_nodes(input bit store);
		int n;
		int ties;
		int target;
		int best_i;
		logic [CNT_W-1:0] cnt [NODE_MAX];
		logic [63:0] wt [NODE_MAX];
		logic [63:0] w;
		logic [CNT_W-1:0] best_c;
		logic [63:0] best_w;
		result_t r;
		n = (model_count > NODE_MAX) ? NODE_MAX : model_count;
		model_lfsr = (model_seed != 0) ? model_seed : 32'd1;
		if (n == 0) begin
			model_unvisited = '0;
			return;
		end
		model_unvisited = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
		while (model_unvisited != 0) begin
			for (int i = 0; i < n; i++)
				cnt[i] = CNT_W'($countones(model_rows[i] & model_unvisited));
			ties = 0;
			best_c = '0;
			best_w = '0;
			for (int i = 0; i < n; i++) begin
				if (!model_unvisited[i])
					continue;
				w = 64'd1;
				for (int c = 0; c < n; c++) begin
					if (model_rows[c][i] && cnt[c] != 0) begin
						w = w * (cnt[c] - 1);
						if (w > WEIGHT_MAX)
							w = WEIGHT_MAX;
					end
				end
				wt[i] = w;
				if (ties == 0 || cnt[i] < best_c || (cnt[i] == best_c && w < best_w)) begin
					best_c = cnt[i];
					best_w = w;
					ties = 1;
				end else if (cnt[i] == best_c && w == best_w) begin
					ties++;
				end
			end
			target = model_lfsr % ties;
			model_lfsr = (model_lfsr >> 1) ^ (model_lfsr[0] ? LFSR_TAPS : 32'd0);
			best_i = 0;
			for (int i = 0; i < n; i++) begin
				if (model_unvisited[i] && cnt[i] == best_c && wt[i] == best_w) begin
					if (target == 0) begin
						best_i = i;
						break;
					end
					target--;
				end
			end
			model_unvisited[best_i] = 1'b0;
			r.picked_node = NODE_W'(best_i);
			r.last = (model_unvisited == 0);
			if (store)
				pending_picks.insert(pending_picks.size(), r);
		end
	endfunction

	function automatic void accept_request(input request_t req, input bit store);
		if (req.action == ACT_LOAD)
			model_rows[req.node_index] = req.parent_mask;
		else
			order_nodes(store);
	endfunction

	task automatic drive_request(input request_t req, input bit store);
		if (allow_gaps && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		accept_request(req, store);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_picks.size() != 0 || busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NODE_COUNT)
			model_count = val[CNT_W-1:0];
		else if (idx == CFG_RANDOM_SEED)
			model_seed = val;
		@(posedge clk);
	endtask

	function automatic request_t rand_request(input int n, input int run_pct);
		request_t q;
		q.action = ($urandom_range(0, 99) < run_pct) ? ACT_RUN : ACT_LOAD;
		q.node_index = NODE_W'(($urandom_range(0, 9) == 0) ? $urandom
			: $urandom_range(0, n - 1));
		case ($urandom_range(0, 2))
			0: q.parent_mask = $urandom;
			1: q.parent_mask = $urandom & $urandom & $urandom;
			default: q.parent_mask = $urandom & ((n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1));
		endcase
		return q;
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_picks.size() == 0) begin
				$error("unexpected result picked_node=%0d last=%0d", result.picked_node, result.last);
				errors++;
			end else begin
				if (result.picked_node !== pending_picks[0].picked_node) begin
					$error("picked_node expected %0d actual %0d",
						pending_picks[0].picked_node, result.picked_node);
					errors++;
				end
				if (result.last !== pending_picks[0].last) begin
					$error("last expected %0d actual %0d", pending_picks[0].last, result.last);
					errors++;
				end
				void'(pending_picks.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		request_t rq;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		allow_gaps = 1'b1;
		foreach (model_rows[i])
			model_rows[i] = '0;
		model_unvisited = '0;
		model_lfsr = 32'd1;
		model_count = 6'd32;
		model_seed = 32'd1;

		rw = '{ROW_CFG, '0, CFG_NODE_COUNT, 32'd1, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_RUN, 5'd0, 32'd0}, '0, '0, 1, '{5'd0, 1'b1}, '0};
		rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_LOAD, 5'd0, 32'd0}, '0, '0, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_LOAD, 5'd1, 32'd1}, '0, '0, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_NODE_COUNT, 32'd2, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_RUN, 5'd31, 32'hFFFF_FFFF}, '0, '0, 2, '{5'd0, 1'b0},
			'{5'd1, 1'b1}}; rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_NODE_COUNT, 32'd0, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_RUN, 5'd0, 32'd0}, '0, '0, 0, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_RANDOM_SEED, 32'd0, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_SPARE_LO, 32'd5, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_SPARE_HI, 32'hFFFF_FFFF, -1, '0, '0};
		rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_NODE_COUNT, 32'd5, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_LOAD, 5'd2, 32'h0000_0004}, '0, '0, -1, '0, '0};
		rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_LOAD, 5'd3, 32'hFFFF_FFFF}, '0, '0, -1, '0, '0};
		rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_LOAD, 5'd4, 32'h0000_000F}, '0, '0, -1, '0, '0};
		rows.insert(rows.size(), rw);
		rw = '{ROW_REQ, '{ACT_RUN, 5'd0, 32'd0}, '0, '0, -1, '0, '0}; rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_RANDOM_SEED, 32'hFFFF_FFFF, -1, '0, '0};
		rows.insert(rows.size(), rw);
		rw = '{ROW_CFG, '0, CFG_NODE_COUNT, 32'd63, -1, '0, '0}; rows.insert(rows.size(), rw);
		for (int i = 0; i < 4; i++) begin
			rw = '{ROW_REQ, '{ACT_LOAD, 5'(i * 10 + 1), 32'hFFFF_FFFF}, '0, '0, -1, '0, '0};
			rows.insert(rows.size(), rw);
		end
		rw = '{ROW_REQ, '{ACT_RUN, 5'd0, 32'd0}, '0, '0, -1, '0, '0}; rows.insert(rows.size(), rw);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			if (rows[k].kind == ROW_CFG) begin
				wait_idle();
				write_reg(rows[k].cfg_idx, rows[k].cfg_val);
			end else begin
				drive_request(rows[k].req, rows[k].exp_n < 0);
				if (rows[k].exp_n > 0)
					pending_picks.insert(pending_picks.size(), rows[k].exp0);
				if (rows[k].exp_n > 1)
					pending_picks.insert(pending_picks.size(), rows[k].exp1);
			end
		end

		for (int phase = 0; phase < 12; phase++) begin
			wait_idle();
			allow_gaps = (phase < 10);
			n = (phase == 4 || phase == 8) ? 32 : $urandom_range(1, 10);
			write_reg(CFG_NODE_COUNT, (phase == 4) ? 32'd40 : n);
			write_reg(CFG_RANDOM_SEED, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
			for (int k = 0; k < 14; k++) begin
				rq = rand_request(n, (n == 32) ? 0 : 15);
				drive_request(rq, 1'b1);
			end
			rq = rand_request(n, 100);
			drive_request(rq, 1'b1);
		end

		wait_idle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
